FILE: sv/fpd_pkg.sv
// Shared types and constants of the framed packet deframer.
package fpd_pkg;

    localparam int unsigned POS_W = 17;

    localparam logic [7:0]       SEPARATOR_BYTE = 8'h1B;
    localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};

    typedef enum logic [1:0] {
        PART_PLAIN     = 2'd0,
        PART_NAME      = 2'd1,
        PART_SEPARATOR = 2'd2,
        PART_PASSWORD  = 2'd3
    } t_part;

    typedef enum logic [1:0] {
        CFG_START_MARKER      = 2'd0,
        CFG_PROMPT_STATUS     = 2'd1,
        CFG_REQUEST_STATUS    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        is_summary;
        logic [7:0]  payload_byte;
        t_part       payload_part;
        logic        valid_res;
        logic [7:0]  opcode;
        logic [7:0]  box_id;
        logic [7:0]  status_code;
        logic [15:0] length_field;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    typedef struct packed {
        logic    not_empty;
        logic    full;
        t_result head;
    } t_queue_stat;

endpackage

FILE: sv/fpd_ifs.sv
// Channel interfaces: received byte, result and configuration write.
interface fpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface fpd_out_if;
    logic        valid;
    logic        ready;
    logic        is_summary;
    logic [7:0]  payload_byte;
    logic [1:0]  payload_part;
    logic        valid_res;
    logic [7:0]  opcode;
    logic [7:0]  box_id;
    logic [7:0]  status_code;
    logic [15:0] length_field;

    modport source (
        output valid, output is_summary, output payload_byte, output payload_part,
        output valid_res, output opcode, output box_id, output status_code,
        output length_field, input ready
    );
    modport sink (
        input valid, input is_summary, input payload_byte, input payload_part,
        input valid_res, input opcode, input box_id, input status_code,
        input length_field, output ready
    );
endinterface

interface fpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/fpd_front.sv
// Front end: config registers, header capture, payload tagging and summary build.
module fpd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fpd_in_if.sink              i_rx,
    fpd_cfg_if.sink             i_cfg,
    input  fpd_pkg::t_queue_stat i_qstat,
    output fpd_pkg::t_push      o_push
);
    import fpd_pkg::*;

    localparam logic [POS_W-1:0] POS_MARKER  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_OPCODE  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_BOX     = POS_W'(4);
    localparam logic [POS_W-1:0] POS_STATUS  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(6);

    logic [7:0]       r_start, r_prompt, r_request;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_marker, n_marker;
    logic [7:0]       r_opcode, n_opcode;
    logic [15:0]      r_len, n_len;
    logic [7:0]       r_box, n_box;
    logic [7:0]       r_status, n_status;
    logic             r_sep, n_sep;

    logic       accept;
    logic [7:0] b;
    logic       len_bad;

    assign i_rx.ready  = !i_qstat.full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_rx.valid && i_rx.ready;
    assign b           = i_rx.rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_prompt  <= '0;
            r_request <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_START_MARKER:   r_start   <= i_cfg.data;
                CFG_PROMPT_STATUS:  r_prompt  <= i_cfg.data;
                CFG_REQUEST_STATUS: r_request <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_marker = r_marker;
        n_opcode = r_opcode;
        n_len    = r_len;
        n_box    = r_box;
        n_status = r_status;
        n_sep    = r_sep;
        len_bad  = 1'b0;
        o_push   = '0;
        if (accept) begin
            unique case (r_pos)
                POS_MARKER: n_marker = (b == r_start);
                POS_OPCODE: n_opcode = b;
                POS_LEN_HI: n_len    = {b, 8'h00};
                POS_LEN_LO: n_len    = {r_len[15:8], b};
                POS_BOX:    n_box    = b;
                POS_STATUS: n_status = b;
                default: ;
            endcase
            if (i_rx.last_byte) begin
                len_bad = (r_pos >= POS_LEN_LO) && ({1'b0, n_len} != r_pos);
                o_push.valid            = 1'b1;
                o_push.res.is_summary   = 1'b1;
                o_push.res.valid_res    = n_marker && !len_bad;
                o_push.res.opcode       = n_opcode;
                o_push.res.box_id       = n_box;
                o_push.res.status_code  = n_status;
                o_push.res.length_field = n_len;
                o_push.res.payload_part = PART_PLAIN;
                n_pos    = '0;
                n_marker = 1'b0;
                n_opcode = '0;
                n_len    = '0;
                n_box    = '0;
                n_status = '0;
                n_sep    = 1'b0;
            end else begin
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + POS_W'(1);
                end
                if (r_pos >= POS_PAYLOAD) begin
                    o_push.valid            = 1'b1;
                    o_push.res.payload_byte = b;
                    o_push.res.payload_part = PART_PLAIN;
                    if (r_status == r_prompt || r_status == r_request) begin
                        priority if (r_sep) begin
                            o_push.res.payload_part = PART_PASSWORD;
                        end else if (b == SEPARATOR_BYTE) begin
                            o_push.res.payload_part = PART_SEPARATOR;
                            n_sep = 1'b1;
                        end else begin
                            o_push.res.payload_part = PART_NAME;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_marker <= 1'b0;
            r_opcode <= '0;
            r_len    <= '0;
            r_box    <= '0;
            r_status <= '0;
            r_sep    <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_marker <= n_marker;
            r_opcode <= n_opcode;
            r_len    <= n_len;
            r_box    <= n_box;
            r_status <= n_status;
            r_sep    <= n_sep;
        end
    end

endmodule

FILE: sv/fpd_queue.sv
// Two-entry result queue between the front end and the output stage.
module fpd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpd_pkg::t_push       i_push,
    input  logic                 i_pop,
    output fpd_pkg::t_queue_stat o_stat
);
    import fpd_pkg::*;

    t_result    r_mem [0:1];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign push = i_push.valid && !o_stat.full;
    assign pop  = i_pop && o_stat.not_empty;

    assign o_stat.not_empty = (r_count != 2'd0);
    assign o_stat.full      = (r_count == 2'd2);
    assign o_stat.head      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_stat.full)
        else $error("result pushed into full queue");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1 && pop && !push) |=> !o_stat.not_empty)
        else $error("queue not empty after last entry popped");
`endif

endmodule

FILE: sv/fpd_back.sv
// Output register stage driving the result channel.
module fpd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpd_pkg::t_queue_stat i_qstat,
    output logic                 o_pop,
    fpd_out_if.source            o_res
);
    import fpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_pop = i_qstat.not_empty && (!r_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_qstat.head;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.is_summary   = r_res.is_summary;
    assign o_res.payload_byte = r_res.payload_byte;
    assign o_res.payload_part = r_res.payload_part;
    assign o_res.valid_res    = r_res.valid_res;
    assign o_res.opcode       = r_res.opcode;
    assign o_res.box_id       = r_res.box_id;
    assign o_res.status_code  = r_res.status_code;
    assign o_res.length_field = r_res.length_field;

endmodule

FILE: sv/framed_packet_deframer_core.sv
// Packet deframer: one received byte per beat in, payload and end-of-packet summary beats out.
// Takes one byte per clock and gives at most one result beat per byte, so it sustains one
// byte per cycle when the result side keeps up. An accepted byte's result is written into
// the queue, then into the output register that drives the output. A two-entry queue sits
// between the byte classifier and the output register; input ready drops only when that
// queue is full. Bytes 0 to 5 are header, the flagged last byte yields the summary, bytes in
// between leave as payload, tagged name, separator or password when the status byte matches
// either credential status register. Configuration writes are always ready.
module framed_packet_deframer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpd_in_if.sink    i_rx,
    fpd_cfg_if.sink   i_cfg,
    fpd_out_if.source o_res
);
    import fpd_pkg::*;

    t_push       push;
    t_queue_stat qstat;
    logic        pop;

    fpd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (i_cfg),
        .i_qstat (qstat),
        .o_push  (push)
    );

    fpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_stat  (qstat)
    );

    fpd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of framed_packet_deframer_core: directed frames, random frames, idling.
module tb;
    import fpd_pkg::*;

    localparam int         DRAIN_CYCLES = 8;
    localparam logic [1:0] CFG_NO_REG   = 2'd3;

    class deframe_scoreboard;
        logic [7:0]       marker_reg;
        logic [7:0]       prompt_reg;
        logic [7:0]       request_reg;
        logic [POS_W-1:0] pos;
        logic             marker_ok;
        logic             sep_seen;
        logic [7:0]       op;
        logic [7:0]       box;
        logic [7:0]       status;
        logic [15:0]      len;
        t_result          expected_q[$];
        int               errors;
        int               payload_cnt;
        int               summary_cnt;

        function new();
            marker_reg  = '0;
            prompt_reg  = '0;
            request_reg = '0;
            errors      = 0;
            payload_cnt = 0;
            summary_cnt = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos       = '0;
            marker_ok = 1'b0;
            sep_seen  = 1'b0;
            op        = '0;
            box       = '0;
            status    = '0;
            len       = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_START_MARKER:   marker_reg  = val;
                CFG_PROMPT_STATUS:  prompt_reg  = val;
                CFG_REQUEST_STATUS: request_reg = val;
                default: ;
            endcase
        endfunction

        // Accepted byte: update frame state, queue the payload or summary beat it causes.
        function void note_byte(logic [7:0] b, logic lastb);
            t_result          r;
            logic [POS_W-1:0] at;
            r  = '0;
            at = pos;
            case (at)
                0: marker_ok = (b == marker_reg);
                1: op = b;
                2: len = {b, 8'h00};
                3: len = {len[15:8], b};
                4: box = b;
                5: status = b;
                default: ;
            endcase
            if (lastb) begin
                r.is_summary   = 1'b1;
                r.valid_res    = marker_ok && (at < 3 || {1'b0, len} == at);
                r.opcode       = op;
                r.box_id       = box;
                r.status_code  = status;
                r.length_field = len;
                expected_q.push_back(r);
                clear_frame();
                return;
            end
            if (pos != POS_MAX)
                pos++;
            if (at >= 6) begin
                r.payload_byte = b;
                if (status == prompt_reg || status == request_reg) begin
                    if (sep_seen) begin
                        r.payload_part = PART_PASSWORD;
                    end else if (b == SEPARATOR_BYTE) begin
                        r.payload_part = PART_SEPARATOR;
                        sep_seen       = 1'b1;
                    end else begin
                        r.payload_part = PART_NAME;
                    end
                end else begin
                    r.payload_part = PART_PLAIN;
                end
                expected_q.push_back(r);
            end
        endfunction

        function void report(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t result beat with nothing expected: %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            if (want.is_summary)
                summary_cnt++;
            else
                payload_cnt++;
            report("is_summary", want.is_summary, got.is_summary);
            report("payload_byte", want.payload_byte, got.payload_byte);
            report("payload_part", want.payload_part, got.payload_part);
            report("valid_res", want.valid_res, got.valid_res);
            report("opcode", want.opcode, got.opcode);
            report("box_id", want.box_id, got.box_id);
            report("status_code", want.status_code, got.status_code);
            report("length_field", want.length_field, got.length_field);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fpd_in_if  rx_if ();
    fpd_cfg_if cfg_if ();
    fpd_out_if res_if ();

    framed_packet_deframer_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    deframe_scoreboard sb = new();
    t_result           got_beat;
    int                idle_mode = 0;
    int                stall_left = 0;
    int                bytes_sent = 0;
    int                packets_sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 2 ? 3 : 11) == 0) begin
            stall_left = $urandom_range(0, 11);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(cfg_if.index, cfg_if.data);
            if (rx_if.valid && rx_if.ready)
                sb.note_byte(rx_if.rx_byte, rx_if.last_byte);
            if (res_if.valid && res_if.ready) begin
                got_beat.is_summary   = res_if.is_summary;
                got_beat.payload_byte = res_if.payload_byte;
                got_beat.payload_part = t_part'(res_if.payload_part);
                got_beat.valid_res    = res_if.valid_res;
                got_beat.opcode       = res_if.opcode;
                got_beat.box_id       = res_if.box_id;
                got_beat.status_code  = res_if.status_code;
                got_beat.length_field = res_if.length_field;
                sb.check_result(got_beat);
            end
        end
    end

    // Enter at a falling edge, leave at the falling edge after the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic lastb);
        if (idle_mode != 0 && $urandom_range(0, idle_mode == 2 ? 3 : 11) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        rx_if.valid     <= 1'b1;
        rx_if.rx_byte   <= b;
        rx_if.last_byte <= lastb;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input int n, input logic [7:0] mk, input logic [15:0] len,
                              input logic [7:0] st);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            case (i)
                0: b = mk;
                2: b = len[15:8];
                3: b = len[7:0];
                5: b = st;
                default: b = (i >= 6 && $urandom_range(0, 5) == 0) ? SEPARATOR_BYTE
                                                                    : 8'($urandom);
            endcase
            send_byte(b, i == n - 1);
        end
        packets_sent++;
    endtask

    task automatic drain();
        rx_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] mk, input logic [7:0] pr, input logic [7:0] rq);
        cfg_write(CFG_START_MARKER, mk);
        cfg_write(CFG_PROMPT_STATUS, pr);
        cfg_write(CFG_REQUEST_STATUS, rq);
        cfg_write(CFG_NO_REG, 8'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        int          target;
        int          kind;
        int          n;
        logic [7:0]  mk;
        logic [7:0]  st;
        logic [15:0] len;
        logic        lastb;
        logic [7:0]  p5[10];

        i_rst_n          = 1'b0;
        rx_if.valid      = 1'b0;
        rx_if.rx_byte    = '0;
        rx_if.last_byte  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        res_if.ready     = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames on reset register values, then with credential tagging.
        idle_mode = 1;
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_frame(4, 8'h00, 16'h0003, 8'h00);
        drain();
        set_regs(8'hA5, 8'h00, 8'hFF);

        send_byte(8'hA5, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        drain();
        // status now matches the request register mid-frame
        cfg_write(CFG_REQUEST_STATUS, 8'h5A);
        cfg_if.valid <= 1'b0;
        send_byte(8'h61, 1'b0);
        send_byte(SEPARATOR_BYTE, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(SEPARATOR_BYTE, 1'b0);
        send_byte(8'h00, 1'b1);

        p5 = '{8'hA5, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h33, 8'h00, 8'hFF, SEPARATOR_BYTE, 8'h7F};
        foreach (p5[i])
            send_byte(p5[i], i == 9);
        packets_sent += 4;

        for (int phase = 0; phase < 5; phase++) begin
            drain();
            case (phase)
                0: set_regs(8'hFF, 8'h00, 8'hFF);
                1: set_regs(8'h00, 8'hFF, 8'hFF);
                default: set_regs(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            target = bytes_sent + 140;
            while (bytes_sent < target) begin
                idle_mode = (phase == 4) ? 0 : $urandom_range(0, 2);
                kind      = $urandom_range(0, 9);
                n         = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                        : $urandom_range(1, 24);
                if (kind < 2) begin
                    do begin
                        lastb = ($urandom_range(0, 5) == 0);
                        send_byte(8'($urandom), lastb);
                    end while (!lastb);
                    packets_sent++;
                end else begin
                    mk  = (kind == 2) ? 8'($urandom) : sb.marker_reg;
                    len = (kind == 3) ? 16'($urandom) : (kind == 4) ? 16'(n) : 16'(n - 1);
                    case ($urandom_range(0, 3))
                        0: st = sb.prompt_reg;
                        1: st = sb.request_reg;
                        default: st = 8'($urandom);
                    endcase
                    send_frame(n, mk, len, st);
                end
            end
        end
        drain();

        $display("%0d bytes in %0d frames across several register settings",
                 bytes_sent, packets_sent);
        $display("%0d payload and %0d summary beats checked", sb.payload_cnt, sb.summary_cnt);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d result beats outstanding", sb.expected_q.size());
        $display("Verification failed");
        $finish;
    end
endmodule
